### design/dvl_pkg.sv
// Shared types and constants for the velocity-log datagram parser.
// No dependencies; imported by every module of the block.
package dvl_pkg;

   localparam int DEFAULT_MAX_FRAMES = 4;

   // Bytes ahead of the offset table: sync, header, size (two), spare, count.
   localparam int HEADER_LEN = 6;

   localparam logic [7:0]  SYNC_BYTE_RST   = 8'h7f;
   localparam logic [7:0]  HEADER_BYTE_RST = 8'h7f;
   localparam logic [15:0] VEL_ID_RST      = 16'h0358;
   localparam logic [15:0] RANGE_ID_RST    = 16'h0458;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SYNC_BYTE   = 2'd0,
      CSR_HEADER_BYTE = 2'd1,
      CSR_VEL_ID      = 2'd2,
      CSR_RANGE_ID    = 2'd3
   } csr_idx_type;

   typedef enum logic [3:0] {
      PH_SYNC    = 4'd0,
      PH_HEADER  = 4'd1,
      PH_SIZE_LO = 4'd2,
      PH_SIZE_HI = 4'd3,
      PH_SPARE   = 4'd4,
      PH_COUNT   = 4'd5,
      PH_OFFSETS = 4'd6,
      PH_WAIT    = 4'd7,
      PH_ID_LO   = 4'd8,
      PH_VEL_SB  = 4'd9,
      PH_VEL_FW  = 4'd10,
      PH_VEL_UP  = 4'd11,
      PH_RANGE   = 4'd12
   } phase_type;

   typedef struct packed {
      logic [7:0]  sync_byte;
      logic [7:0]  header_byte;
      logic [15:0] vel_id;
      logic [15:0] range_id;
   } cfg_type;

   typedef struct packed {
      logic signed [31:0] vel_starboard;
      logic signed [31:0] vel_forward;
      logic signed [31:0] vel_upward;
      logic signed [31:0] bottom_range;
      logic [31:0]        update_count;
   } result_type;

endpackage

### design/dvl_parser.sv
// Byte-wide datagram parser: phase machine, offset table and held values.
// Depends on dvl_pkg.
module dvl_parser #(
   parameter int MAX_FRAMES = dvl_pkg::DEFAULT_MAX_FRAMES
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               byte_valid,
   input  logic [7:0]         rx_byte,
   input  dvl_pkg::cfg_type   cfg,
   output logic               res_valid,
   output dvl_pkg::result_type res
);
   import dvl_pkg::*;

   localparam int CNT_W = $clog2(MAX_FRAMES + 1);
   localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int OBI_W = CNT_W + 1;

   phase_type          phase_ff, phase_in;
   logic [CNT_W-1:0]   total_ff, total_in;
   logic [15:0]        offsets_ff [MAX_FRAMES];
   logic [OBI_W-1:0]   obi_ff, obi_in;
   logic [15:0]        pos_ff, pos_in;
   logic [CNT_W-1:0]   nfi_ff, nfi_in;
   logic [7:0]         fid_hi_ff, fid_hi_in;
   logic [1:0]         vbi_ff, vbi_in;
   logic [31:0]        held_ff [4];
   logic [31:0]        count_ff, count_in;

   logic               hdr_ok, count_bad, offsets_last, wait_done, wait_hit;
   logic               is_vel, is_range, is_value, value_last;
   logic [15:0]        fid_word;
   logic [CNT_W-1:0]   slot;
   logic [1:0]         held_sel;
   logic [31:0]        held_new;
   logic [OBI_W:0]     obi_next;

   assign hdr_ok       = (rx_byte == cfg.header_byte);
   assign count_bad    = (rx_byte == 8'd0) || (rx_byte > 8'(MAX_FRAMES));
   assign obi_next     = {1'b0, obi_ff} + (OBI_W+1)'(1);
   assign offsets_last = obi_next >= {1'b0, total_ff, 1'b0};
   assign slot         = obi_ff[OBI_W-1:1];
   assign wait_done    = (nfi_ff >= total_ff);
   assign wait_hit     = (pos_ff == offsets_ff[nfi_ff[IDX_W-1:0]]);
   assign fid_word     = {fid_hi_ff, rx_byte};
   assign is_vel       = (fid_word == cfg.vel_id);
   assign is_range     = (fid_word == cfg.range_id);
   assign value_last   = (vbi_ff == 2'd3);

   always_comb begin
      is_value = 1'b1;
      held_sel = 2'd0;
      case (phase_ff)
         PH_VEL_SB: held_sel = 2'd0;
         PH_VEL_FW: held_sel = 2'd1;
         PH_VEL_UP: held_sel = 2'd2;
         PH_RANGE:  held_sel = 2'd3;
         default:   is_value = 1'b0;
      endcase
   end

   // Little-endian assembly: the first byte clears the upper lanes.
   always_comb begin
      held_new = held_ff[held_sel];
      if (vbi_ff == 2'd0) begin
         held_new = {24'd0, rx_byte};
      end else begin
         for (int k = 1; k < 4; k++) begin
            if (vbi_ff == 2'(k)) begin
               held_new[k*8 +: 8] = rx_byte;
            end
         end
      end
   end

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_SYNC:    if (rx_byte == cfg.sync_byte) phase_in = PH_HEADER;
         PH_HEADER:  phase_in = hdr_ok ? PH_SIZE_LO : PH_SYNC;
         PH_SIZE_LO: phase_in = PH_SIZE_HI;
         PH_SIZE_HI: phase_in = PH_SPARE;
         PH_SPARE:   phase_in = PH_COUNT;
         PH_COUNT:   phase_in = count_bad ? PH_SYNC : PH_OFFSETS;
         PH_OFFSETS: if (offsets_last) phase_in = PH_WAIT;
         PH_WAIT: begin
            if (wait_done) begin
               phase_in = PH_SYNC;
            end else if (wait_hit) begin
               phase_in = PH_ID_LO;
            end
         end
         PH_ID_LO: begin
            if (is_vel) begin
               phase_in = PH_VEL_SB;
            end else if (is_range) begin
               phase_in = PH_RANGE;
            end else begin
               phase_in = PH_WAIT;
            end
         end
         PH_VEL_SB:  if (value_last) phase_in = PH_VEL_FW;
         PH_VEL_FW:  if (value_last) phase_in = PH_VEL_UP;
         PH_VEL_UP:  if (value_last) phase_in = PH_WAIT;
         PH_RANGE:   if (value_last) phase_in = PH_SYNC;
         default:    phase_in = PH_SYNC;
      endcase
   end

   // Counters, indexes and the result.
   always_comb begin
      total_in  = total_ff;
      obi_in    = obi_ff;
      pos_in    = pos_ff;
      nfi_in    = nfi_ff;
      fid_hi_in = fid_hi_ff;
      vbi_in    = vbi_ff;
      count_in  = count_ff;
      res_valid = 1'b0;
      res.vel_starboard = held_ff[0];
      res.vel_forward   = held_ff[1];
      res.vel_upward    = held_ff[2];
      res.bottom_range  = held_new;
      res.update_count  = count_ff + 32'd1;
      case (phase_ff)
         PH_COUNT: begin
            total_in = rx_byte[CNT_W-1:0];
            obi_in   = '0;
         end
         PH_OFFSETS: begin
            if (offsets_last) begin
               pos_in = 16'(HEADER_LEN) + 16'({total_ff, 1'b0});
               nfi_in = '0;
            end else begin
               obi_in = obi_next[OBI_W-1:0];
            end
         end
         PH_WAIT: begin
            if (!wait_done) begin
               pos_in = pos_ff + 16'd1;
               if (wait_hit) begin
                  fid_hi_in = rx_byte;
                  nfi_in    = nfi_ff + CNT_W'(1);
               end
            end
         end
         PH_ID_LO: begin
            pos_in = pos_ff + 16'd1;
            vbi_in = 2'd0;
         end
         default: begin
            if (is_value) begin
               pos_in = pos_ff + 16'd1;
               vbi_in = value_last ? 2'd0 : vbi_ff + 2'd1;
               if (phase_ff == PH_RANGE && value_last) begin
                  res_valid = 1'b1;
                  count_in  = count_ff + 32'd1;
               end
            end
         end
      endcase
      if (!byte_valid) begin
         res_valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SYNC;
         total_ff  <= '0;
         obi_ff    <= '0;
         pos_ff    <= '0;
         nfi_ff    <= '0;
         fid_hi_ff <= '0;
         vbi_ff    <= '0;
         count_ff  <= '0;
         for (int k = 0; k < 4; k++) begin
            held_ff[k] <= '0;
         end
      end else if (byte_valid) begin
         phase_ff  <= phase_in;
         total_ff  <= total_in;
         obi_ff    <= obi_in;
         pos_ff    <= pos_in;
         nfi_ff    <= nfi_in;
         fid_hi_ff <= fid_hi_in;
         vbi_ff    <= vbi_in;
         count_ff  <= count_in;
         if (is_value) begin
            held_ff[held_sel] <= held_new;
         end
      end
   end

   // Offset table: no reset, every entry is written before it is compared.
   always_ff @(posedge clock) begin
      if (byte_valid && phase_ff == PH_OFFSETS) begin
         if (!obi_ff[0]) begin
            offsets_ff[slot[IDX_W-1:0]] <= {8'd0, rx_byte};
         end else begin
            offsets_ff[slot[IDX_W-1:0]][15:8] <= rx_byte;
         end
      end
   end

endmodule

### design/dvl_out_buf.sv
// Two-entry result buffer: output register plus skid register.
// Depends on dvl_pkg.
module dvl_out_buf (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  dvl_pkg::result_type push_data,
   output logic                full,
   output logic                out_valid,
   input  logic                out_stall,
   output dvl_pkg::result_type out_data
);
   import dvl_pkg::*;

   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type out_ff, out_in;
   result_type skid_ff, skid_in;
   logic       pop;

   assign pop       = out_valid_ff && !out_stall;
   assign full      = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         // No push can arrive while the skid entry is occupied.
         if (pop) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_in       = push_data;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

endmodule

### design/dvl_datagram_velocity_parser_top.sv
// Top level of the velocity-log datagram parser: configuration registers,
// parser core and result buffer. Depends on dvl_pkg, dvl_parser, dvl_out_buf.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid / req_stall  req_rx_byte
//   rsp_      out        rsp_valid / rsp_stall  velocities, range, update count
//   csr_      in         csr_wr_en              csr_index, csr_wdata
//
// Each accepted byte beat is parsed in the cycle it is accepted; a result
// from the last range byte is registered in the output or skid entry before
// it shows on rsp_. The sustained rate is one byte per cycle while req_stall
// is low, set by the single parse step between the phase registers and the
// two-entry result buffer. req_stall is raised only while both result entries
// are full, so input beats keep flowing while one finished result waits to
// be taken. Reset is synchronous and active high; it restores the register
// defaults, the sync hunt, the held values and the update count.
module dvl_datagram_velocity_parser_top #(
   parameter int MAX_FRAMES = dvl_pkg::DEFAULT_MAX_FRAMES
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [7:0]                        req_rx_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [31:0]                rsp_vel_starboard,
   output logic signed [31:0]                rsp_vel_forward,
   output logic signed [31:0]                rsp_vel_upward,
   output logic signed [31:0]                rsp_bottom_range,
   output logic [31:0]                       rsp_update_count,
   input  logic                              csr_wr_en,
   input  logic [dvl_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [dvl_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import dvl_pkg::*;

   cfg_type    cfg_ff;
   logic       byte_accept;
   logic       res_valid;
   result_type res;
   result_type out_data;
   logic       buf_full;

   // Configuration registers; each write keeps only the register's width.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_byte   <= SYNC_BYTE_RST;
         cfg_ff.header_byte <= HEADER_BYTE_RST;
         cfg_ff.vel_id      <= VEL_ID_RST;
         cfg_ff.range_id    <= RANGE_ID_RST;
      end else if (csr_wr_en) begin
         unique case (csr_idx_type'(csr_index))
            CSR_SYNC_BYTE:   cfg_ff.sync_byte   <= csr_wdata[7:0];
            CSR_HEADER_BYTE: cfg_ff.header_byte <= csr_wdata[7:0];
            CSR_VEL_ID:      cfg_ff.vel_id      <= csr_wdata;
            CSR_RANGE_ID:    cfg_ff.range_id    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign req_stall   = buf_full;
   assign byte_accept = req_valid && !buf_full;

   dvl_parser #(
      .MAX_FRAMES (MAX_FRAMES)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (byte_accept),
      .rx_byte    (req_rx_byte),
      .cfg        (cfg_ff),
      .res_valid  (res_valid),
      .res        (res)
   );

   dvl_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .full      (buf_full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (out_data)
   );

   assign rsp_vel_starboard = out_data.vel_starboard;
   assign rsp_vel_forward   = out_data.vel_forward;
   assign rsp_vel_upward    = out_data.vel_upward;
   assign rsp_bottom_range  = out_data.bottom_range;
   assign rsp_update_count  = out_data.update_count;

endmodule

### sim/dvl_datagram_velocity_parser_top_tb.sv
// Self-checking bench for the velocity-log datagram parser top level.
// Holds a scoreboard class that predicts fixes byte by byte; depends on dvl_pkg and the RTL.
`timescale 1ns / 1ps

module dvl_datagram_velocity_parser_top_tb;
   import dvl_pkg::*;

   localparam int FRAMES = DEFAULT_MAX_FRAMES;

   // The scoreboard mirrors the parser state. Every accepted byte beat is fed to
   // take_byte, which queues a navigation fix whenever a range value completes;
   // check_fix compares each delivered fix with the oldest one queued.
   class fix_scoreboard;
      cfg_type     cfg;
      phase_type   phase;
      logic [15:0] dg_size;
      logic [7:0]  n_frames;
      logic [15:0] offs [FRAMES];
      logic [2:0]  off_idx;
      logic [15:0] pos;
      logic [2:0]  frame_idx;
      logic [15:0] fid_word;
      logic [1:0]  val_idx;
      logic [31:0] held [4];
      logic [31:0] fix_count;
      result_type  fixes_due [$];
      int          errors;
      int          fixes_seen;

      function new();
         cfg.sync_byte   = SYNC_BYTE_RST;
         cfg.header_byte = HEADER_BYTE_RST;
         cfg.vel_id      = VEL_ID_RST;
         cfg.range_id    = RANGE_ID_RST;
         foreach (held[i]) held[i] = '0;
         fix_count  = '0;
         errors     = 0;
         fixes_seen = 0;
         clear_parse();
      endfunction

      function void set_reg(csr_idx_type idx, logic [15:0] data);
         case (idx)
            CSR_SYNC_BYTE:   cfg.sync_byte   = data[7:0];
            CSR_HEADER_BYTE: cfg.header_byte = data[7:0];
            CSR_VEL_ID:      cfg.vel_id      = data;
            CSR_RANGE_ID:    cfg.range_id    = data;
            default: ;
         endcase
      endfunction

      // Giving up on a datagram forgets everything but the held values and the count.
      function void clear_parse();
         phase     = PH_SYNC;
         dg_size   = '0;
         n_frames  = '0;
         foreach (offs[i]) offs[i] = '0;
         off_idx   = '0;
         pos       = '0;
         frame_idx = '0;
         fid_word  = '0;
         val_idx   = '0;
      endfunction

      // Little-endian assembly of one 32-bit value; true on its last byte.
      function bit take_value_byte(int slot, logic [7:0] b);
         if (val_idx == 2'd0)
            held[slot] = {24'h000000, b};
         else
            held[slot][8*val_idx +: 8] = b;
         pos = pos + 16'd1;
         if (val_idx == 2'd3) begin
            val_idx = 2'd0;
            return 1'b1;
         end
         val_idx = val_idx + 2'd1;
         return 1'b0;
      endfunction

      function void take_byte(logic [7:0] b);
         result_type fix;
         int         slot;
         case (phase)
            PH_SYNC: begin
               if (b == cfg.sync_byte) phase = PH_HEADER;
            end
            PH_HEADER: begin
               if (b == cfg.header_byte) phase = PH_SIZE_LO;
               else clear_parse();
            end
            PH_SIZE_LO: begin
               dg_size = {8'h00, b};
               phase   = PH_SIZE_HI;
            end
            PH_SIZE_HI: begin
               dg_size[15:8] = b;
               phase         = PH_SPARE;
            end
            PH_SPARE: phase = PH_COUNT;
            PH_COUNT: begin
               if (b == 8'd0 || b > FRAMES) begin
                  clear_parse();
               end else begin
                  n_frames = b;
                  off_idx  = '0;
                  phase    = PH_OFFSETS;
               end
            end
            PH_OFFSETS: begin
               slot = off_idx >> 1;
               if (off_idx[0] == 1'b0)
                  offs[slot] = {8'h00, b};
               else
                  offs[slot][15:8] = b;
               if (int'(off_idx) + 1 >= 2 * int'(n_frames)) begin
                  phase     = PH_WAIT;
                  pos       = 16'(HEADER_LEN + 2 * int'(n_frames));
                  frame_idx = '0;
               end else begin
                  off_idx = off_idx + 3'd1;
               end
            end
            PH_WAIT: begin
               if (frame_idx >= n_frames || frame_idx >= FRAMES) begin
                  clear_parse();
               end else begin
                  if (pos == offs[frame_idx]) begin
                     fid_word  = {b, 8'h00};
                     phase     = PH_ID_LO;
                     frame_idx = frame_idx + 3'd1;
                  end
                  pos = pos + 16'd1;
               end
            end
            PH_ID_LO: begin
               fid_word[7:0] = b;
               pos           = pos + 16'd1;
               val_idx       = '0;
               // Velocity is tested first, so it wins when both IDs are equal.
               if (fid_word == cfg.vel_id) phase = PH_VEL_SB;
               else if (fid_word == cfg.range_id) phase = PH_RANGE;
               else phase = PH_WAIT;
            end
            PH_VEL_SB: if (take_value_byte(0, b)) phase = PH_VEL_FW;
            PH_VEL_FW: if (take_value_byte(1, b)) phase = PH_VEL_UP;
            PH_VEL_UP: if (take_value_byte(2, b)) phase = PH_WAIT;
            PH_RANGE: begin
               if (take_value_byte(3, b)) begin
                  fix_count         = fix_count + 32'd1;
                  fix.vel_starboard = held[0];
                  fix.vel_forward   = held[1];
                  fix.vel_upward    = held[2];
                  fix.bottom_range  = held[3];
                  fix.update_count  = fix_count;
                  fixes_due.push_back(fix);
                  clear_parse();
               end
            end
            default: clear_parse();
         endcase
      endfunction

      function void check_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%08h, actual 0x%08h", $time, name, want, got);
         end
      endfunction

      function void check_fix(result_type got);
         result_type want;
         if (fixes_due.size() == 0) begin
            errors++;
            $display("%0t: result beat with none expected, actual update_count 0x%08h",
                     $time, got.update_count);
            return;
         end
         want = fixes_due.pop_front();
         fixes_seen++;
         check_field("vel_starboard", want.vel_starboard, got.vel_starboard);
         check_field("vel_forward", want.vel_forward, got.vel_forward);
         check_field("vel_upward", want.vel_upward, got.vel_upward);
         check_field("bottom_range", want.bottom_range, got.bottom_range);
         check_field("update_count", want.update_count, got.update_count);
      endfunction
   endclass

   // Every input of the block starts at a known value.
   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   logic [7:0]            req_rx_byte = 8'h00;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   logic signed [31:0]    rsp_vel_starboard;
   logic signed [31:0]    rsp_vel_forward;
   logic signed [31:0]    rsp_vel_upward;
   logic signed [31:0]    rsp_bottom_range;
   logic [31:0]           rsp_update_count;
   logic                  csr_wr_en   = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata   = '0;

   fix_scoreboard sb;

   // Stimulus is built as whole byte sequences before it is sent, so that the
   // layout of each datagram (offsets, payload lengths) can follow the current
   // register settings. Every sequence leaves the parser back in its sync hunt.
   logic [7:0]  burst_q [$];
   logic [31:0] word_plan [$];
   logic [15:0] plan_id [FRAMES];
   int          plan_gap [FRAMES];
   int          planned_bytes = 0;
   int          planned_fixes = 0;
   int          bytes_taken   = 0;
   int          settings_used = 0;

   // Idle percentages for either side, and a counter that asks the receiver
   // for one long hold-off.
   int send_idle_pct = 31;
   int rcv_idle_pct  = 68;
   int hold_asked    = 0;
   int hold_done     = 0;
   int hold_left     = 0;

   dvl_datagram_velocity_parser_top i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_vel_starboard (rsp_vel_starboard),
      .rsp_vel_forward   (rsp_vel_forward),
      .rsp_vel_upward    (rsp_vel_upward),
      .rsp_bottom_range  (rsp_bottom_range),
      .rsp_update_count  (rsp_update_count),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Receiver: random stall per cycle, or a long hold-off when one is asked for.
   // The hold-off lets the two-entry result buffer fill so that the block has
   // to stall its byte input while the sender keeps offering beats.
   always @(posedge clock) begin
      if (hold_asked != hold_done) begin
         hold_done = hold_asked;
         hold_left = 400;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
      end
   end

   // Both channels are sampled at the rising edge, before any update made at
   // that edge, so a beat counts exactly when the block sees it. The byte is
   // fed to the scoreboard before any result beat of that edge is checked.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            sb.take_byte(req_rx_byte);
            bytes_taken++;
         end
         if (rsp_valid && !rsp_stall)
            sb.check_fix(result_type'({rsp_vel_starboard, rsp_vel_forward, rsp_vel_upward,
                                       rsp_bottom_range, rsp_update_count}));
      end
   end

   // Offers one byte beat and returns at the edge that accepts it. Before the
   // beat the sender idles cycle by cycle with its idle chance; valid stays
   // high into the next beat unless an idle cycle follows.
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do
         @(posedge clock);
      while (req_stall);
   endtask

   task automatic send_burst(input bit counted);
      if (counted)
         planned_bytes += burst_q.size();
      while (burst_q.size() != 0)
         send_byte(burst_q.pop_front());
   endtask

   // Lowers valid and waits until every queued fix has been delivered. The
   // first edge lets the scoreboard take the final beat before it is looked at.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.fixes_due.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input csr_idx_type idx, input logic [15:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      sb.set_reg(idx, data);
      @(posedge clock);
   endtask

   // The byte registers get random upper bits, which the block should ignore.
   task automatic write_cfg(input logic [7:0] s, input logic [7:0] h,
                            input logic [15:0] v, input logic [15:0] r);
      write_reg(CSR_SYNC_BYTE, {8'($urandom), s});
      write_reg(CSR_HEADER_BYTE, {8'($urandom), h});
      write_reg(CSR_VEL_ID, v);
      write_reg(CSR_RANGE_ID, r);
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   function automatic logic [31:0] next_word();
      logic [31:0] w;
      if (word_plan.size() != 0)
         return word_plan.pop_front();
      case ($urandom_range(19))
         0:       w = 32'h7fffffff;
         1:       w = 32'h80000000;
         2:       w = 32'hffffffff;
         3:       w = 32'h00000000;
         default: w = $urandom();
      endcase
      return w;
   endfunction

   function automatic void push_word(input logic [31:0] w);
      for (int k = 0; k < 4; k++)
         burst_q.push_back(w[8*k +: 8]);
   endfunction

   function automatic logic [7:0] any_byte();
      return 8'($urandom_range(255));
   endfunction

   // An ID that the parser will treat as an unknown frame.
   function automatic logic [15:0] stray_id();
      logic [15:0] id;
      do
         id = 16'($urandom_range(65535));
      while (id == sb.cfg.vel_id || id == sb.cfg.range_id);
      return id;
   endfunction

   // Bytes the parser consumes after a frame ID, judged as the block will.
   function automatic int payload_len(input logic [15:0] id);
      if (id == sb.cfg.vel_id)
         return 12;
      if (id == sb.cfg.range_id)
         return 4;
      return 0;
   endfunction

   // Builds a datagram of n frames from plan_id and plan_gap. Offsets point at
   // each frame ID; gap bytes are filler the parser counts past. The stream stops
   // at the first range frame, which ends the datagram; without one, a single
   // trailing byte finds every frame visited and sends the parser back to sync.
   function automatic void add_datagram(input int n);
      int          p;
      logic [15:0] offs [FRAMES];
      p = HEADER_LEN + 2 * n;
      for (int i = 0; i < n; i++) begin
         offs[i] = 16'(p + plan_gap[i]);
         p       = p + plan_gap[i] + 2 + payload_len(plan_id[i]);
      end
      burst_q.push_back(sb.cfg.sync_byte);
      burst_q.push_back(sb.cfg.header_byte);
      burst_q.push_back(any_byte());
      burst_q.push_back(any_byte());
      burst_q.push_back(any_byte());
      burst_q.push_back(8'(n));
      for (int i = 0; i < n; i++) begin
         burst_q.push_back(offs[i][7:0]);
         burst_q.push_back(offs[i][15:8]);
      end
      for (int i = 0; i < n; i++) begin
         repeat (plan_gap[i]) burst_q.push_back(any_byte());
         burst_q.push_back(plan_id[i][15:8]);
         burst_q.push_back(plan_id[i][7:0]);
         if (plan_id[i] == sb.cfg.vel_id) begin
            repeat (3) push_word(next_word());
         end else if (plan_id[i] == sb.cfg.range_id) begin
            push_word(next_word());
            planned_fixes++;
            return;
         end
      end
      burst_q.push_back(any_byte());
   endfunction

   function automatic void add_random_datagram(input bit force_range);
      int n;
      int r;
      n = $urandom_range(FRAMES, 1);
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if (i == n - 1)
            plan_id[i] = (force_range || r < 80) ? sb.cfg.range_id :
                         (r < 90 ? sb.cfg.vel_id : stray_id());
         else
            plan_id[i] = (r < 50) ? sb.cfg.vel_id : (r < 88 ? stray_id() : sb.cfg.range_id);
         plan_gap[i] = ($urandom_range(99) < 75) ? $urandom_range(2) : $urandom_range(24, 3);
      end
      add_datagram(n);
   endfunction

   function automatic void add_bad_count(input logic [7:0] c);
      burst_q.push_back(sb.cfg.sync_byte);
      burst_q.push_back(sb.cfg.header_byte);
      repeat (3) burst_q.push_back(any_byte());
      burst_q.push_back(c);
   endfunction

   // Sync followed by a wrong header byte; where the two registers differ, the
   // wrong byte is often the sync byte itself, which must not restart the hunt.
   function automatic void add_header_slip();
      logic [7:0] b;
      b = any_byte();
      if (sb.cfg.sync_byte != sb.cfg.header_byte && $urandom_range(1) == 1)
         b = sb.cfg.sync_byte;
      if (b == sb.cfg.header_byte)
         b = ~b;
      burst_q.push_back(sb.cfg.sync_byte);
      burst_q.push_back(b);
   endfunction

   // Line noise, rich in sync bytes, that never completes a sync and header pair.
   function automatic void add_noise(input int k);
      logic [7:0] b;
      bit         in_hdr;
      in_hdr = 1'b0;
      repeat (k) begin
         b = ($urandom_range(3) == 0) ? sb.cfg.sync_byte : any_byte();
         if (in_hdr) begin
            if (b == sb.cfg.header_byte)
               b = ~b;
            in_hdr = 1'b0;
         end else if (b == sb.cfg.sync_byte) begin
            in_hdr = 1'b1;
         end
         burst_q.push_back(b);
      end
      if (in_hdr)
         burst_q.push_back(~sb.cfg.header_byte);
   endfunction

   // Mostly well-formed datagrams with random content, the rest noise and
   // broken headers. Runs until enough bytes and enough fixes have been planned.
   task automatic random_mix(input int byte_goal, input int fix_goal);
      int bytes0;
      int fixes0;
      int r;
      bytes0 = planned_bytes;
      fixes0 = planned_fixes;
      while (planned_bytes - bytes0 < byte_goal || planned_fixes - fixes0 < fix_goal) begin
         r = $urandom_range(99);
         if (r < 72) begin
            add_random_datagram(1'b0);
            send_burst(1'b1);
         end else if (r < 82) begin
            add_noise($urandom_range(8, 1));
            send_burst(1'b0);
         end else if (r < 90) begin
            add_header_slip();
            send_burst(1'b1);
         end else begin
            add_bad_count(($urandom_range(1) == 1) ? 8'd0 : 8'($urandom_range(255, FRAMES + 1)));
            send_burst(1'b1);
         end
      end
   endtask

   initial begin
      logic [15:0] v_id;
      logic [15:0] r_id;
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part under the reset settings, with the sender idling 31 and
      // the receiver 68 percent of the time. Velocity then range, with the
      // extreme signed values.
      word_plan   = '{32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h00000000};
      plan_id[0]  = sb.cfg.vel_id;
      plan_gap[0] = 0;
      plan_id[1]  = sb.cfg.range_id;
      plan_gap[1] = 0;
      add_datagram(2);
      // A range-only datagram reports the velocities held from before.
      word_plan.push_back(32'h80000000);
      plan_id[0]  = sb.cfg.range_id;
      plan_gap[0] = 3;
      add_datagram(1);
      // Frame counts of zero and above the limit, and a header that slips.
      add_bad_count(8'd0);
      add_bad_count(8'(FRAMES + 1));
      add_bad_count(8'hff);
      add_header_slip();
      add_noise(6);
      // The full frame table: velocity, unknown, repeated velocity, range.
      plan_id  = '{sb.cfg.vel_id, stray_id(), sb.cfg.vel_id, sb.cfg.range_id};
      plan_gap = '{1, 0, 2, 5};
      add_datagram(FRAMES);
      // No range frame: the byte after the last frame runs out of frames.
      plan_id[0]  = sb.cfg.vel_id;
      plan_gap[0] = 0;
      add_datagram(1);
      plan_id[0]  = stray_id();
      plan_id[1]  = stray_id();
      plan_gap[1] = 4;
      add_datagram(2);
      // A range frame listed first ends the datagram early.
      plan_id  = '{sb.cfg.range_id, sb.cfg.vel_id, sb.cfg.vel_id, sb.cfg.vel_id};
      plan_gap = '{0, 0, 0, 0};
      add_datagram(3);
      send_burst(1'b1);
      settle();

      // Extreme settings, one way round.
      write_cfg(8'h00, 8'hff, 16'hffff, 16'h0000);
      random_mix(250, 6);
      settle();

      // Sender now idles more than the receiver; the opposite extremes.
      send_idle_pct = 68;
      rcv_idle_pct  = 31;
      write_cfg(8'hff, 8'h00, 16'h0000, 16'hffff);
      random_mix(250, 6);
      settle();

      // Equal frame IDs: velocity wins, so no range value and no fix can come.
      v_id = 16'($urandom_range(65535));
      write_cfg(any_byte(), any_byte(), v_id, v_id);
      random_mix(60, 0);
      settle();

      // No idling at all; random settings with distinct IDs.
      send_idle_pct = 0;
      rcv_idle_pct  = 0;
      do begin
         v_id = 16'($urandom_range(65535));
         r_id = 16'($urandom_range(65535));
      end while (v_id == r_id);
      write_cfg(any_byte(), any_byte(), v_id, r_id);
      // Long receiver hold-off while short datagrams stream in back to back.
      hold_asked++;
      repeat (8) begin
         add_random_datagram(1'b1);
         send_burst(1'b1);
      end
      random_mix(200, 6);
      settle();

      $display("Summary: %0d byte beats accepted, %0d fixes checked, %0d register settings.",
               bytes_taken, sb.fixes_seen, settings_used);
      $display("Covered idling on both sides, a long receiver hold-off and broken datagrams.");
      if (sb.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #400_000;
      $display("Timed out with %0d fixes outstanding", sb.fixes_due.size());
      $display("FAIL");
      $finish;
   end

endmodule

### files.f
design/dvl_pkg.sv
design/dvl_parser.sv
design/dvl_out_buf.sv
design/dvl_datagram_velocity_parser_top.sv
sim/dvl_datagram_velocity_parser_top_tb.sv
